// ===== sv/cdq_pkg.sv =====
// Shared types and constants for the circular double-ended queue.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int CFG_W   = 11;
    localparam int VALUE_W = 32;

    localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
    localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
    localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
    localparam logic [1:0] FUNC_POP_BACK   = 2'd3;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic                      is_empty;
        logic                      is_full;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;   // apply the accepted word: move indices, write the slot
        logic rd;     // read the front and back slots
        logic load;   // capture the result into the output register
    } t_cmd;

endpackage

// ===== sv/cdq_ctrl.sv =====
// Controller state machine for the circular double-ended queue.
`timescale 1ns / 1ps

module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/cdq_dp.sv =====
// Datapath for the circular double-ended queue: indices, slot memory, result register.
`timescale 1ns / 1ps

module cdq_dp
    import cdq_pkg::*;
#(
    parameter int MAX_DEPTH = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in_word         i_in_word,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_out_word        o_out_word
);

    localparam int AW = $clog2(MAX_DEPTH);
    localparam int CW = AW + 1;

    function automatic logic [CW-1:0] f_clamp(input logic [CFG_W-1:0] c);
        logic [31:0] w;
        begin
            w = 32'(c);
            if (w == 32'd0) begin
                return CW'(1);
            end else if (w > 32'(MAX_DEPTH)) begin
                return CW'(MAX_DEPTH);
            end
            return CW'(w);
        end
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] i,
                                            input logic [CW-1:0] cap);
        logic [CW-1:0] t;
        begin
            t = {1'b0, i} + CW'(1);
            return (t >= cap) ? '0 : t[AW-1:0];
        end
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] i,
                                            input logic [CW-1:0] cap);
        logic [CW-1:0] c1;
        logic [CW-1:0] wi;
        begin
            c1 = cap - CW'(1);
            wi = {1'b0, i};
            return (wi == '0 || wi > cap) ? c1[AW-1:0] : i - AW'(1);
        end
    endfunction

    logic [VALUE_W-1:0] mem [MAX_DEPTH];

    logic [CW-1:0] r_cap;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_last, n_last;
    logic          r_ok,   n_ok;

    logic [VALUE_W-1:0] r_rd_front, r_rd_back;
    t_out_word          r_out;

    logic          same, full, empty;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign same  = (r_head == r_tail);
    assign full  = same && r_last;
    assign empty = same && !r_last;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_last  = r_last;
        n_ok    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_tail;
        unique case (i_in_word.func)
            FUNC_PUSH_FRONT: begin
                if (!full) begin
                    n_head  = f_dec(r_head, r_cap);
                    wr_addr = n_head;
                    wr_en   = 1'b1;
                    n_last  = 1'b1;
                    n_ok    = 1'b1;
                end
            end
            FUNC_PUSH_BACK: begin
                if (!full) begin
                    wr_addr = r_tail;
                    wr_en   = 1'b1;
                    n_tail  = f_inc(r_tail, r_cap);
                    n_last  = 1'b1;
                    n_ok    = 1'b1;
                end
            end
            FUNC_POP_FRONT: begin
                if (!empty) begin
                    n_head = f_inc(r_head, r_cap);
                    n_last = 1'b0;
                    n_ok   = 1'b1;
                end
            end
            FUNC_POP_BACK: begin
                if (!empty) begin
                    n_tail = f_dec(r_tail, r_cap);
                    n_last = 1'b0;
                    n_ok   = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Control state: a capacity write also empties the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= f_clamp(CFG_W'(1024));
            r_head <= '0;
            r_tail <= '0;
            r_last <= 1'b0;
        end else if (i_cfg_we) begin
            r_cap  <= f_clamp(i_cfg_data);
            r_head <= '0;
            r_tail <= '0;
            r_last <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= i_in_word.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_front <= mem[r_head];
            r_rd_back  <= mem[f_dec(r_tail, r_cap)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.ok          <= r_ok;
            r_out.front_value <= empty ? '1 : r_rd_front;
            r_out.back_value  <= empty ? '1 : r_rd_back;
            r_out.is_empty    <= empty;
            r_out.is_full     <= full;
        end
    end

    assign o_out_word = r_out;

endmodule

// ===== sv/circular_double_ended_queue.sv =====
// Top level of the circular double-ended queue: controller plus datapath.
`timescale 1ns / 1ps
// An accepted word first moves the indices and writes its slot, then the front
// and back slots are read, then the result is loaded once the output register is free.
// A new word is taken only after that load; the slot read follows the index update.
// The output register lets the next word enter while a result waits.
// Reset (i_rst_n, synchronous, active low): queue empty, capacity 1024.
// Slot memory has no reset; empty reads return -1 without touching it.

module circular_double_ended_queue
    import cdq_pkg::*;
#(
    parameter int MAX_DEPTH = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Commands: exec applies the word, rd fetches front/back slots,
    // load moves the finished result into the output register.
    t_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Datapath holds head/tail indices, the push flag that tells full from
    // empty when the indices meet, the slot memory and the result register.
    cdq_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_word (o_out_word)
    );

endmodule

// ===== verif/circular_double_ended_queue_tb.sv =====
// Self-checking testbench for the circular double-ended queue.
`timescale 1ns / 1ps

module circular_double_ended_queue_tb;
    import cdq_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int LATENCY    = 2;      // base of the settle pad below
    localparam int QUIET_PAD  = LATENCY + 5;
    localparam int WATCH_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int RAND_PHASES = 14;
    localparam int PHASE_WORDS = 80;

    // ------------------------------------------------------------------
    // Deque predictor and result store. It keeps its own copy of the ring,
    // the indices and the capacity, and queues one expected result word
    // per accepted input word.
    // ------------------------------------------------------------------
    class deque_scoreboard;
        logic [VALUE_W-1:0] ring [DEPTH];
        int unsigned        head;
        int unsigned        tail;
        bit                 last_push;
        int unsigned        cap_reg;
        t_out_word          expected_q [$];
        int                 errors;
        int                 checked;
        int                 refused;
        int                 full_seen;
        int                 settings;

        function new();
            cap_reg   = DEPTH;
            head      = 0;
            tail      = 0;
            last_push = 1'b0;
            errors    = 0;
            checked   = 0;
            refused   = 0;
            full_seen = 0;
            settings  = 0;
        endfunction

        // Out-of-range capacities clamp: zero acts as one, above DEPTH as DEPTH.
        function int unsigned used_cap();
            if (cap_reg == 0) return 1;
            if (cap_reg > DEPTH) return DEPTH;
            return cap_reg;
        endfunction

        function int unsigned step_up(int unsigned i, int unsigned c);
            return (i + 1 >= c) ? 0 : i + 1;
        endfunction

        function int unsigned step_down(int unsigned i, int unsigned c);
            return (i == 0 || i > c) ? c - 1 : i - 1;
        endfunction

        // A capacity write also empties the queue.
        function void set_capacity(int unsigned c);
            cap_reg   = c;
            head      = 0;
            tail      = 0;
            last_push = 1'b0;
            settings++;
        endfunction

        function void note_input(t_in_word w);
            int unsigned c;
            bit          full;
            bit          empty;
            t_out_word   res;
            c     = used_cap();
            full  = (head == tail) && last_push;
            empty = (head == tail) && !last_push;
            res   = '0;
            case (w.func)
                FUNC_PUSH_FRONT: begin
                    if (!full) begin
                        head       = step_down(head, c);
                        ring[head] = w.value;
                        last_push  = 1'b1;
                        res.ok     = 1'b1;
                    end
                end
                FUNC_PUSH_BACK: begin
                    if (!full) begin
                        ring[tail] = w.value;
                        tail       = step_up(tail, c);
                        last_push  = 1'b1;
                        res.ok     = 1'b1;
                    end
                end
                FUNC_POP_FRONT: begin
                    if (!empty) begin
                        head      = step_up(head, c);
                        last_push = 1'b0;
                        res.ok    = 1'b1;
                    end
                end
                default: begin
                    if (!empty) begin
                        tail      = step_down(tail, c);
                        last_push = 1'b0;
                        res.ok    = 1'b1;
                    end
                end
            endcase
            full  = (head == tail) && last_push;
            empty = (head == tail) && !last_push;
            if (empty) begin
                res.front_value = '1;
                res.back_value  = '1;
            end else begin
                res.front_value = ring[head];
                res.back_value  = ring[step_down(tail, c)];
            end
            res.is_empty = empty;
            res.is_full  = full;
            if (!res.ok) refused++;
            if (full) full_seen++;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                    logic [VALUE_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $error("result %0d: %s expected %h actual %h", checked, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (expected_q.size() == 0) begin
                $error("result word with no expectation waiting: %h", got);
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            compare_field("ok", exp_w.ok, got.ok);
            compare_field("front_value", exp_w.front_value, got.front_value);
            compare_field("back_value", exp_w.back_value, got.back_value);
            compare_field("is_empty", exp_w.is_empty, got.is_empty);
            compare_field("is_full", exp_w.is_full, got.is_full);
            checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_word         i_in_word;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_word        o_out_word;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    deque_scoreboard  sb;
    bit               idle_on;
    int               idle_cycles;

    circular_double_ended_queue #(
        .MAX_DEPTH (DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: hold ready high, but drop it low at random while idling is
    // enabled. One assignment per falling edge at most.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Check every result word accepted at a rising edge against the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_word);
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCH_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Bias toward the signed extremes, zero and the all-ones word, which also
    // reads like the empty marker.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Drive one input word. Called at a falling edge, returns at a falling
    // edge with valid still high so a following word keeps it up.
    task automatic send_word(input logic [1:0] op, input logic [VALUE_W-1:0] data);
        t_in_word w;
        w.func  = op;
        w.value = data;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(w);
        @(negedge i_clk);
    endtask

    // Write the capacity only once the queue has drained all results and
    // the pipeline has had time to settle.
    task automatic write_capacity(input int unsigned c);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (QUIET_PAD) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_capacity(c);
    endtask

    // One random phase: pushes versus pops weighted, weight re-picked every
    // 20 words so the queue swings between empty and full on small rings.
    task automatic run_phase(input int unsigned c, input int words);
        int          push_pct;
        logic [1:0]  op;
        write_capacity(c);
        push_pct = 50;
        for (int n = 0; n < words; n++) begin
            if (n % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            if ($urandom_range(0, 99) < push_pct) begin
                op = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
            end else begin
                op = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
            end
            send_word(op, pick_value());
        end
    endtask

    int unsigned phase_caps [RAND_PHASES] = '{3, 1, 2, 2047, 5, 16, 0, 4,
                                              1024, 7, 1025, 2, 9, 64};

    initial begin
        sb          = new();
        idle_on     = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_on = 1'b1;

        // Reset capacity: refused pops on empty, front push wraps the head
        // to the top slot, then drain from both ends past empty.
        send_word(FUNC_POP_FRONT,  32'h0000_0000);
        send_word(FUNC_POP_BACK,   32'h0000_0000);
        send_word(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(FUNC_PUSH_BACK,  32'h8000_0000);
        send_word(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(FUNC_PUSH_BACK,  32'h0000_0000);
        send_word(FUNC_POP_FRONT,  32'h0000_0000);
        send_word(FUNC_POP_BACK,   32'h0000_0000);
        send_word(FUNC_POP_BACK,   32'h0000_0000);
        send_word(FUNC_POP_FRONT,  32'h0000_0000);
        send_word(FUNC_POP_FRONT,  32'h0000_0000);

        // Single slot: full after one push, refused pushes at both ends.
        write_capacity(1);
        send_word(FUNC_PUSH_BACK,  32'h1234_5678);
        send_word(FUNC_PUSH_FRONT, 32'hDEAD_BEEF);
        send_word(FUNC_PUSH_BACK,  32'hDEAD_BEEF);
        send_word(FUNC_POP_BACK,   32'h0000_0000);
        send_word(FUNC_POP_BACK,   32'h0000_0000);
        send_word(FUNC_PUSH_FRONT, 32'hAAAA_AAAA);
        send_word(FUNC_POP_FRONT,  32'h0000_0000);

        // Zero capacity acts as one slot.
        write_capacity(0);
        send_word(FUNC_PUSH_FRONT, 32'h5555_5555);
        send_word(FUNC_PUSH_BACK,  32'h0000_0001);
        send_word(FUNC_POP_BACK,   32'h0000_0000);

        // All-ones capacity clamps to the full depth.
        write_capacity(2047);
        send_word(FUNC_PUSH_FRONT, 32'h0000_0001);
        send_word(FUNC_POP_BACK,   32'h0000_0000);

        // Two slots: fill from both ends.
        write_capacity(2);
        send_word(FUNC_PUSH_BACK,  32'hCAFE_0001);
        send_word(FUNC_PUSH_FRONT, 32'hCAFE_0002);

        // Random phases over several capacities; no idling in the last two.
        for (int p = 0; p < RAND_PHASES; p++) begin
            idle_on = (p >= RAND_PHASES - 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            run_phase(phase_caps[p], PHASE_WORDS);
        end

        // Drain: release valid, wait for every result, then let the pipe settle.
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (QUIET_PAD) @(negedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end

        $display("checked %0d result words over %0d capacity settings",
                 sb.checked, sb.settings);
        $display("%0d refused operations, %0d results reported a full queue",
                 sb.refused, sb.full_seen);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_dp.sv
sv/circular_double_ended_queue.sv
verif/circular_double_ended_queue_tb.sv
